@@ src/first_fit_capacity_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// First-fit capacity allocator: assertion macros
// Implication checks on a clock, masked while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CAPACITY_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CAPACITY_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffca assertion failed");

// next-cycle implication
`define FFCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffca assertion failed");

`endif

@@ src/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit capacity allocator package
// Field widths, command and status codes, parameter defaults.
// ----------------------------------------------------------------------------
package ffca_pkg;

   localparam int NUM_BINS_DEF = 1024;
   localparam int CAP_BITS_DEF = 32;

   localparam int CMD_W     = 1;
   localparam int BIN_IDX_W = 10;
   localparam int AMOUNT_W  = 32;
   localparam int STATUS_W  = 2;
   localparam int BIN_NUM_W = 11;
   localparam int COUNT_W   = 11;

   localparam logic [COUNT_W-1:0] BIN_COUNT_RST = 11'd1024;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_LOADED   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ASSIGNED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_ROOM  = 2'd2;

endpackage

@@ src/first_fit_capacity_allocator.sv @@
// ----------------------------------------------------------------------------
// First-fit capacity allocator
// Max tree over the free capacity of a row of bins, held in one memory with
// two read ports and one write port. A load sets one bin; an allocate finds
// the leftmost bin that can hold the size, takes the size from it and
// returns its 1-based number.
//
//   channel | direction | word
//   req     | in        | command, bin index, amount
//   rsp     | out       | status, bin number
//   csr     | in        | bin count
//
// One word at a time: a walk from the root reading both children of one
// node a cycle, then a write back of the path from leaf to root, one node a
// cycle. A load beyond the bins in use skips both, and a failed allocate
// skips the write back.
// After reset a clearing pass over all 2*NUM_BINS entries zeroes the tree;
// no word is taken meanwhile. A held result stalls the next word only at its
// end.
// ----------------------------------------------------------------------------
module first_fit_capacity_allocator #(
   parameter int NUM_BINS = ffca_pkg::NUM_BINS_DEF,
   parameter int CAP_BITS = ffca_pkg::CAP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ffca_pkg::CMD_W-1:0]          req_command,
   input  logic [ffca_pkg::BIN_IDX_W-1:0]      req_bin_index,
   input  logic [ffca_pkg::AMOUNT_W-1:0]       req_amount,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ffca_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ffca_pkg::BIN_NUM_W-1:0]      rsp_bin_number,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffca_pkg::COUNT_W-1:0]        csr_bin_count
);
   import ffca_pkg::*;

   localparam int LVL   = $clog2(NUM_BINS);
   localparam int AW    = LVL + 1;
   localparam int LVW   = $clog2(LVL + 1);
   localparam int DEPTH = 2 * NUM_BINS;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_WRITE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [AW-1:0]            node_ff, node_in;
   logic [LVW-1:0]           level_ff, level_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [LVL-1:0]           path_ff, path_in;
   logic [CAP_BITS-1:0]      amt_ff, amt_in;
   logic [CAP_BITS-1:0]      val_ff, val_in;
   logic [CAP_BITS-1:0]      sib_ff [LVL+1];
   logic                     sib_we;
   logic [CAP_BITS-1:0]      sib_wd;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [BIN_NUM_W-1:0]     res_bin_ff, res_bin_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [BIN_NUM_W-1:0]     rsp_bin_ff, rsp_bin_in;
   logic [COUNT_W-1:0]       bin_count_ff, bin_count_in;

   logic [CAP_BITS-1:0]      tree_mem_ff [DEPTH];
   logic [CAP_BITS-1:0]      rd_l_ff, rd_r_ff;
   logic [AW-1:0]            rd_la, rd_ra, mem_wa;
   logic [CAP_BITS-1:0]      mem_wd;
   logic                     mem_we;

   logic                     req_fire;
   logic [31:0]              used;
   logic                     dir;
   logic [CAP_BITS-1:0]      chosen;
   logic [LVL-1:0]           found;
   logic                     fit;
   logic                     out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_bin_number = rsp_bin_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign used = (32'(bin_count_ff) > 32'(NUM_BINS)) ? 32'(NUM_BINS) : 32'(bin_count_ff);

   // tree memory: two registered reads, one write
   assign rd_la = {node_in[AW-2:0], 1'b0};
   assign rd_ra = {node_in[AW-2:0], 1'b1};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem_ff[mem_wa] <= mem_wd;
      end
      rd_l_ff <= tree_mem_ff[rd_la];
      rd_r_ff <= tree_mem_ff[rd_ra];
   end

   always_ff @(posedge clock) begin
      if (sib_we) begin
         sib_ff[LVW'(level_ff + 1'b1)] <= sib_wd;
      end
   end

   always_comb begin
      dir    = (cmd_ff == CMD_ALLOC) ? (rd_l_ff < amt_ff) : path_ff[LVL-1];
      chosen = dir ? rd_r_ff : rd_l_ff;
      sib_wd = dir ? rd_l_ff : rd_r_ff;
      found  = node_in[LVL-1:0];
      fit    = (cmd_ff == CMD_LOAD) ||
               ((chosen >= amt_ff) && (32'(found) < used));
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      level_in      = level_ff;
      cmd_in        = cmd_ff;
      path_in       = path_ff;
      amt_in        = amt_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_bin_in    = res_bin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_bin_in    = rsp_bin_ff;
      bin_count_in  = (csr_valid && csr_ready) ? csr_bin_count : bin_count_ff;
      sib_we        = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = node_ff;
      mem_wd        = val_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            node_in  = AW'(1);
            level_in = '0;
            if (req_fire) begin
               cmd_in  = req_command;
               path_in = LVL'(req_bin_index);
               amt_in  = CAP_BITS'(req_amount);
               res_status_in = STAT_LOADED;
               res_bin_in    = '0;
               if (req_command == CMD_LOAD && !(32'(req_bin_index) < used)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            sib_we   = 1'b1;
            node_in  = {node_ff[AW-2:0], dir};
            level_in = LVW'(level_ff + 1'b1);
            path_in  = path_ff << 1;
            if (level_ff == LVW'(LVL - 1)) begin
               if (cmd_ff == CMD_ALLOC) begin
                  val_in = chosen - amt_ff;
               end else begin
                  val_in = amt_ff;
               end
               if (!fit) begin
                  res_status_in = STAT_NO_ROOM;
                  res_bin_in    = '0;
                  state_in      = ST_FINISH;
               end else begin
                  if (cmd_ff == CMD_ALLOC) begin
                     res_status_in = STAT_ASSIGNED;
                     res_bin_in    = BIN_NUM_W'(32'(found) + 32'd1);
                  end
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            node_in  = node_ff >> 1;
            level_in = LVW'(level_ff - 1'b1);
            if (level_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               val_in = (sib_ff[level_ff] > val_ff) ? sib_ff[level_ff] : val_ff;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bin_in    = res_bin_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         bin_count_ff <= BIN_COUNT_RST;
         level_ff     <= '0;
         node_ff      <= AW'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         bin_count_ff <= bin_count_in;
         level_ff     <= level_in;
         node_ff      <= node_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      path_ff       <= path_in;
      amt_ff        <= amt_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_bin_ff    <= res_bin_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bin_ff    <= rsp_bin_in;
   end

`include "first_fit_capacity_allocator_assert.svh"

   `FFCA_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire,
      (state_ff == ST_WALK) || (state_ff == ST_FINISH))
   `FFCA_ASSERT_NOW(a_walk_depth, clock, reset, state_ff == ST_WALK,
      level_ff < LVW'(LVL))
   `FFCA_ASSERT_NOW(a_write_path, clock, reset, state_ff == ST_WRITE,
      (node_ff >> level_ff) == AW'(1))
   `FFCA_ASSERT_NOW(a_assigned_nonzero, clock, reset,
      rsp_valid && (rsp_status == STAT_ASSIGNED), rsp_bin_number != '0)
   `FFCA_ASSERT_NOW(a_no_room_zero, clock, reset,
      rsp_valid && (rsp_status != STAT_ASSIGNED), rsp_bin_number == '0)

endmodule
